// ----- design/pep_pkg.sv -----
// ----------------------------------------------------------------------------
// pep_pkg
// Shared types, constants and the sine table builder for the particle
// emitter frame update block.
// ----------------------------------------------------------------------------
package pep_pkg;

    // store and table sizes
    localparam int MAX_PARTICLES = 64;
    localparam int SINE_ENTRIES  = 1024;   // power of two, 64..4096

    localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam int SIN_W = $clog2(SINE_ENTRIES);

    localparam logic [31:0] RNG_SEED = 32'd2463534242;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam logic [16:0] ALPHA_ONE = 17'd65536;
    localparam logic [4:0]  DIV_STEPS = 5'd16;

    // register indexes
    localparam logic [2:0] REG_EMIT_RATE    = 3'd0;
    localparam logic [2:0] REG_SPAWN_RADIUS = 3'd1;
    localparam logic [2:0] REG_SPEED_LOW    = 3'd2;
    localparam logic [2:0] REG_SPEED_HIGH   = 3'd3;
    localparam logic [2:0] REG_LIFE_LOW     = 3'd4;
    localparam logic [2:0] REG_LIFE_HIGH    = 3'd5;
    localparam logic [2:0] REG_SIZE_LOW     = 3'd6;
    localparam logic [2:0] REG_SIZE_HIGH    = 3'd7;

    typedef struct packed {
        logic        [15:0] frame_time;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] quad_left;
        logic signed [31:0] quad_right;
        logic signed [31:0] quad_bottom;
        logic signed [31:0] quad_top;
        logic signed [31:0] quad_depth;
        logic        [16:0] opacity;
        logic               final_quad;
    } t_out_item;

    // one stored particle
    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] life_left;
        logic [31:0] life_start;
        logic [31:0] half_size;
    } t_particle;

    // datapath commands
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ACCUM,
        OP_SP1, OP_SP2, OP_SP3, OP_SP4, OP_SP5, OP_SP6, OP_SP7, OP_SP8, OP_SP9,
        OP_AG_RD,
        OP_AG_CHK,
        OP_AG_MVRD,
        OP_AG_MVWR,
        OP_AG_UPX,
        OP_AG_UPYW,
        OP_EM_INIT,
        OP_EM_RD,
        OP_EM_LD,
        OP_EM_DIV,
        OP_EM_OUT
    } t_op;

    // datapath status back to the controller
    typedef struct packed {
        logic spawn_go;
        logic k_lt_live;
        logic dead;
        logic div_last;
        logic out_free;
    } t_status;

    typedef logic signed [17:0] t_sine_tab [SINE_ENTRIES];

    // quadrant sine, Q2.30 Taylor series, result Q2.16 (18-bit signed)
    function automatic logic signed [17:0] quarter_sine(input longint unsigned rem);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned v;
        x  = (rem * HALF_PI_Q30) / SINE_ENTRIES;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((t * x2) >> 30) / 110;
        t  = ONE_Q30 - ((t * x2) >> 30) / 72;
        t  = ONE_Q30 - ((t * x2) >> 30) / 42;
        t  = ONE_Q30 - ((t * x2) >> 30) / 20;
        t  = ONE_Q30 - ((t * x2) >> 30) / 6;
        v  = (((x * t) >> 30) + 64'd8192) >> 14;
        return $signed(v[17:0]);
    endfunction

    // full-turn sine table
    function automatic t_sine_tab build_sine();
        t_sine_tab tab;
        longint unsigned p;
        longint unsigned q;
        longint unsigned r;
        logic signed [17:0] v;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            p = 64'(4 * i);
            q = (p / SINE_ENTRIES) & 64'd3;
            r = p % SINE_ENTRIES;
            v = quarter_sine(q[0] ? (64'(SINE_ENTRIES) - r) : r);
            tab[i] = q[1] ? -v : v;
        end
        return tab;
    endfunction

endpackage

// ----- design/particle_emitter_frame_update.sv -----
// ----------------------------------------------------------------------------
// particle_emitter_frame_update
// One emitter: spawns, ages and emits quad bounds for up to MAX_PARTICLES
// particles per frame tick.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall | t_in_item, one frame tick
//  out     | output    | o_out_valid / i_out_stall | t_out_item, one quad each
//  cfg     | input     | i_cfg_we               | i_cfg_index, i_cfg_data
//
// a tick's length grows with each spawn, each aged or removed particle
// and each emitted quad; the serial store port and the 17-step alpha
// divider set the cost of each item
// synchronous active-low reset; the particle store is not cleared
// a stalled output holds the sequencer before the next quad, and a new
// tick is taken while the last quad still waits
module particle_emitter_frame_update import pep_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_op     op;
    t_status status;

    // sequencer
    pep_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_op       (op),
        .o_in_stall (o_in_stall)
    );

    // datapath
    pep_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- design/pep_ctrl.sv -----
// ----------------------------------------------------------------------------
// pep_ctrl
// Sequencer for one frame tick: spawn, aging with swap-remove, emission.
// ----------------------------------------------------------------------------
module pep_ctrl import pep_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_op     o_op,
    output logic    o_in_stall
);

    typedef enum logic [4:0] {
        S_IDLE, S_ACCUM, S_SP_HEAD,
        S_SP1, S_SP2, S_SP3, S_SP4, S_SP5, S_SP6, S_SP7, S_SP8, S_SP9,
        S_AG_HEAD, S_AG_RD, S_AG_CHK, S_AG_MVRD, S_AG_MVWR, S_AG_UPX, S_AG_UPYW,
        S_EM_INIT, S_EM_HEAD, S_EM_RD, S_EM_LD, S_EM_DIV, S_EM_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and command
    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_ACCUM;
                end
            end
            S_ACCUM: begin
                o_op    = OP_ACCUM;
                n_state = S_SP_HEAD;
            end
            S_SP_HEAD: n_state = i_status.spawn_go ? S_SP1 : S_AG_HEAD;
            S_SP1: begin o_op = OP_SP1; n_state = S_SP2; end
            S_SP2: begin o_op = OP_SP2; n_state = S_SP3; end
            S_SP3: begin o_op = OP_SP3; n_state = S_SP4; end
            S_SP4: begin o_op = OP_SP4; n_state = S_SP5; end
            S_SP5: begin o_op = OP_SP5; n_state = S_SP6; end
            S_SP6: begin o_op = OP_SP6; n_state = S_SP7; end
            S_SP7: begin o_op = OP_SP7; n_state = S_SP8; end
            S_SP8: begin o_op = OP_SP8; n_state = S_SP9; end
            S_SP9: begin o_op = OP_SP9; n_state = S_SP_HEAD; end
            S_AG_HEAD: n_state = i_status.k_lt_live ? S_AG_RD : S_EM_INIT;
            S_AG_RD: begin o_op = OP_AG_RD; n_state = S_AG_CHK; end
            S_AG_CHK: begin
                o_op    = OP_AG_CHK;
                n_state = i_status.dead ? S_AG_MVRD : S_AG_UPX;
            end
            S_AG_MVRD: begin o_op = OP_AG_MVRD; n_state = S_AG_MVWR; end
            S_AG_MVWR: begin o_op = OP_AG_MVWR; n_state = S_AG_HEAD; end
            S_AG_UPX:  begin o_op = OP_AG_UPX;  n_state = S_AG_UPYW; end
            S_AG_UPYW: begin o_op = OP_AG_UPYW; n_state = S_AG_HEAD; end
            S_EM_INIT: begin o_op = OP_EM_INIT; n_state = S_EM_HEAD; end
            S_EM_HEAD: n_state = i_status.k_lt_live ? S_EM_RD : S_IDLE;
            S_EM_RD: begin o_op = OP_EM_RD; n_state = S_EM_LD; end
            S_EM_LD: begin o_op = OP_EM_LD; n_state = S_EM_DIV; end
            S_EM_DIV: begin
                o_op = OP_EM_DIV;
                if (i_status.div_last) begin
                    n_state = S_EM_OUT;
                end
            end
            S_EM_OUT: begin
                if (i_status.out_free) begin
                    o_op    = OP_EM_OUT;
                    n_state = S_EM_HEAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ----- design/pep_datapath.sv -----
// ----------------------------------------------------------------------------
// pep_datapath
// Registers, particle store, sine table, random source, alpha divider and
// output register, driven by the sequencer's commands.
// ----------------------------------------------------------------------------
module pep_datapath import pep_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    input  t_in_item    i_in_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_out_stall,
    output t_status     o_status,
    output logic        o_out_valid,
    output t_out_item   o_out_data
);

    localparam t_sine_tab SINE_TAB = build_sine();
    localparam logic [SIN_W-1:0] QUARTER = SIN_W'(SINE_ENTRIES / 4);

    // configuration
    logic [26:0] r_emit_rate;
    logic [30:0] r_spawn_radius;
    logic [31:0] r_speed_low, r_speed_high;
    logic [30:0] r_life_low, r_life_high, r_size_low, r_size_high;

    // tick state
    t_in_item         r_in;
    logic [15:0]      r_accum;
    logic [15:0]      r_to_spawn;
    logic [31:0]      r_rng;
    logic [CNT_W-1:0] r_live;
    logic [CNT_W-1:0] r_k;

    // spawn scratch
    logic [SIN_W-1:0]   r_idx;
    logic signed [17:0] r_sn, r_cs, r_rom_q;
    logic [31:0]        r_rad;
    logic signed [31:0] r_spd;
    t_particle          r_work;

    // divider
    logic [33:0] r_rem;
    logic [31:0] r_den;
    logic [16:0] r_quo;
    logic [4:0]  r_div_cnt;
    logic        r_alpha_ok;

    // particle store
    t_particle r_mem [MAX_PARTICLES];
    t_particle r_mem_q;

    logic [SIN_W-1:0] rom_addr;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             mem_we;
    t_particle        wr_data;
    t_particle        aged_work;

    function automatic logic [31:0] xorshift(input logic [31:0] s);
        logic [31:0] x;
        x = s ^ (s << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    // a + floor((b - a) * r / 65536)
    function automatic logic [31:0] lerp(input logic signed [32:0] a,
                                         input logic signed [32:0] b,
                                         input logic [15:0] r);
        logic signed [33:0] d;
        logic signed [50:0] p;
        logic signed [33:0] s;
        d = 34'(b) - 34'(a);
        p = 51'(d) * $signed({35'd0, r});
        s = 34'(a) + 34'(p >>> 16);
        return s[31:0];
    endfunction

    // floor(a * b / 65536), low 32 bits
    function automatic logic [31:0] mulq(input logic signed [32:0] a,
                                         input logic signed [17:0] b);
        logic signed [50:0] p;
        p = 51'(a) * 51'(b);
        return p[47:16];
    endfunction

    logic [31:0]        rng_next;
    logic [15:0]        draw;
    logic [42:0]        rate_prod;
    logic [31:0]        accum_sum;
    logic signed [32:0] aged_life;
    logic signed [17:0] dt_s;
    logic [34:0]        rem_shift;
    logic [16:0]        alpha;

    assign rng_next  = xorshift(r_rng);
    assign draw      = rng_next[31:16];
    assign rate_prod = 43'(r_in.frame_time) * 43'(r_emit_rate);
    assign accum_sum = {16'd0, r_accum} + 32'(rate_prod[42:16]);
    assign dt_s      = $signed({2'b00, r_in.frame_time});
    assign aged_life = $signed({r_mem_q.life_left[31], r_mem_q.life_left})
                     - $signed({17'd0, r_in.frame_time});
    assign rem_shift = {r_rem, (r_div_cnt == DIV_STEPS) ? r_work.life_left[0] : 1'b0};
    assign alpha     = !r_alpha_ok ? 17'd0 : (r_quo > ALPHA_ONE) ? ALPHA_ONE : r_quo;

    // particle after one frame of aging
    always_comb begin
        aged_work           = r_mem_q;
        aged_work.life_left = aged_life[31:0];
    end

    // status to the sequencer
    assign o_status.spawn_go  = (r_to_spawn != 16'd0) && (r_live < CNT_W'(MAX_PARTICLES));
    assign o_status.k_lt_live = (r_k < r_live);
    assign o_status.dead      = (aged_life <= 33'sd0);
    assign o_status.div_last  = (r_div_cnt == 5'd0);
    assign o_status.out_free  = !o_out_valid || !i_out_stall;

    // sine table address
    always_comb begin
        rom_addr = r_idx + QUARTER;
        if (i_op == OP_SP1) begin
            rom_addr = draw[15 -: SIN_W];
        end
    end

    // store addresses and write data
    always_comb begin
        rd_addr = r_k[IDX_W-1:0];
        if (i_op == OP_AG_MVRD) begin
            rd_addr = IDX_W'(r_live - CNT_W'(1));
        end
        wr_addr = r_k[IDX_W-1:0];
        wr_data = r_work;
        mem_we  = 1'b0;
        unique case (i_op)
            OP_SP9: begin
                mem_we        = 1'b1;
                wr_addr       = r_live[IDX_W-1:0];
                wr_data.vel_y = mulq(33'(r_spd), r_sn);
            end
            OP_AG_MVWR: begin
                mem_we  = 1'b1;
                wr_data = r_mem_q;
            end
            OP_AG_UPYW: begin
                mem_we        = 1'b1;
                wr_data.pos_y = r_work.pos_y + mulq(33'($signed(r_work.vel_y)), dt_s);
            end
            default: mem_we = 1'b0;
        endcase
    end

    // particle store write, particle store and sine table reads
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_mem_q <= r_mem[rd_addr];
        r_rom_q <= SINE_TAB[rom_addr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_rate    <= 27'd655360;
            r_spawn_radius <= 31'd65536;
            r_speed_low    <= 32'd65536;
            r_speed_high   <= 32'd131072;
            r_life_low     <= 31'd65536;
            r_life_high    <= 31'd131072;
            r_size_low     <= 31'd6554;
            r_size_high    <= 31'd13107;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_EMIT_RATE:    r_emit_rate    <= i_cfg_data[26:0];
                REG_SPAWN_RADIUS: r_spawn_radius <= i_cfg_data[30:0];
                REG_SPEED_LOW:    r_speed_low    <= i_cfg_data;
                REG_SPEED_HIGH:   r_speed_high   <= i_cfg_data;
                REG_LIFE_LOW:     r_life_low     <= i_cfg_data[30:0];
                REG_LIFE_HIGH:    r_life_high    <= i_cfg_data[30:0];
                REG_SIZE_LOW:     r_size_low     <= i_cfg_data[30:0];
                REG_SIZE_HIGH:    r_size_high    <= i_cfg_data[30:0];
                default:          r_emit_rate    <= r_emit_rate;
            endcase
        end
    end

    // control counters and random state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum    <= 16'd0;
            r_to_spawn <= 16'd0;
            r_rng      <= RNG_SEED;
            r_live     <= '0;
            r_k        <= '0;
            r_div_cnt  <= '0;
        end else begin
            unique case (i_op)
                OP_LOAD: r_k <= '0;
                OP_ACCUM: begin
                    r_accum    <= accum_sum[15:0];
                    r_to_spawn <= accum_sum[31:16];
                end
                OP_SP1, OP_SP2, OP_SP3, OP_SP4, OP_SP5, OP_SP6: r_rng <= rng_next;
                OP_SP9: begin
                    r_live     <= r_live + CNT_W'(1);
                    r_to_spawn <= r_to_spawn - 16'd1;
                end
                OP_AG_MVWR: r_live <= r_live - CNT_W'(1);
                OP_AG_UPYW, OP_EM_OUT: r_k <= r_k + CNT_W'(1);
                OP_EM_INIT: r_k <= '0;
                OP_EM_LD:   r_div_cnt <= DIV_STEPS;
                OP_EM_DIV:  r_div_cnt <= r_div_cnt - 5'd1;
                default:    r_k <= r_k;
            endcase
        end
    end

    // payload scratch
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            OP_LOAD: r_in <= i_in_data;
            OP_SP1: r_idx <= draw[15 -: SIN_W];
            OP_SP2: begin
                r_rad <= 32'((48'(draw) * 48'(r_spawn_radius)) >> 16);
                r_sn  <= r_rom_q;
            end
            OP_SP3: begin
                r_spd <= lerp(33'($signed(r_speed_low)), 33'($signed(r_speed_high)), draw);
                r_cs  <= r_rom_q;
            end
            OP_SP4: begin
                r_work.life_left  <= lerp({2'b00, r_life_low}, {2'b00, r_life_high}, draw);
                r_work.life_start <= lerp({2'b00, r_life_low}, {2'b00, r_life_high}, draw);
            end
            OP_SP5: r_work.half_size <= lerp({2'b00, r_size_low}, {2'b00, r_size_high}, draw);
            OP_SP6: begin
                r_work.pos_x <= r_in.origin_x + mulq({1'b0, r_rad}, r_cs);
                r_work.pos_z <= r_in.origin_z;
            end
            OP_SP7: r_work.pos_y <= r_in.origin_y + mulq({1'b0, r_rad}, r_sn);
            OP_SP8: r_work.vel_x <= mulq(33'(r_spd), r_cs);
            OP_AG_CHK: r_work <= aged_work;
            OP_AG_UPX: r_work.pos_x <= r_work.pos_x
                                     + mulq(33'($signed(r_work.vel_x)), dt_s);
            OP_EM_LD: begin
                r_work     <= r_mem_q;
                r_rem      <= {3'd0, r_mem_q.life_left[31:1]};
                r_den      <= r_mem_q.life_start;
                r_quo      <= '0;
                r_alpha_ok <= ($signed(r_mem_q.life_left) > 32'sd0)
                           && ($signed(r_mem_q.life_start) > 32'sd0);
            end
            OP_EM_DIV: begin
                // one restoring step per cycle
                if (rem_shift >= {3'd0, r_den}) begin
                    r_rem <= 34'(rem_shift - {3'd0, r_den});
                    r_quo <= {r_quo[15:0], 1'b1};
                end else begin
                    r_rem <= rem_shift[33:0];
                    r_quo <= {r_quo[15:0], 1'b0};
                end
            end
            default: r_idx <= r_idx;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_op == OP_EM_OUT) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_EM_OUT) begin
            o_out_data.quad_left   <= r_work.pos_x - r_work.half_size;
            o_out_data.quad_right  <= r_work.pos_x + r_work.half_size;
            o_out_data.quad_bottom <= r_work.pos_y - r_work.half_size;
            o_out_data.quad_top    <= r_work.pos_y + r_work.half_size;
            o_out_data.quad_depth  <= r_work.pos_z;
            o_out_data.opacity     <= alpha;
            o_out_data.final_quad  <= ((r_k + CNT_W'(1)) == r_live);
        end
    end

endmodule
